[rtl/core/rtpq_pkg.sv]
// Shared types and constants for the real-time priority run queue.
// No dependencies.
package rtpq_pkg;
	localparam int LEVELS_DEF = 100;
	localparam int POOL_DEF = 64;
	localparam int TID_BITS_DEF = 16;

	localparam logic [1:0] FUNC_SET  = 2'd0;
	localparam logic [1:0] FUNC_PICK = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [19:0] QUANTUM_RST = 20'd10000;
	localparam logic [19:0] TICK_RST    = 20'd1000;

	localparam logic ADDR_QUANTUM = 1'b0;
	localparam logic ADDR_TICK    = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture input beat
		logic enq_rd;     // read tail of the enqueue level
		logic enq;        // enqueue: link/write entry, update level
		logic enq_cur;    // enqueue source is the current thread
		logic take;       // pop head of highest level
		logic rd_tail;    // read head/tail of the highest level
		logic rd_ent;     // read link, thread and class of the head entry
		logic dec;        // charge tick to current
		logic done;       // emit result
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic set_ok;
		logic pool_full;
		logic any_ne;
		logic cur_rr;
		logic expire;
	} sts_t;
endpackage

[rtl/core/rtpq_ctrl.sv]
// Controller state machine for the run queue.
// Depends on rtpq_pkg.
module rtpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          func,
	output logic                busy,
	input  rtpq_pkg::sts_t      sts,
	output rtpq_pkg::ctl_t      ctl,
	output logic [1:0]          status_d,
	output logic                picked_d
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_ENQ_RD = 3'd2;
	localparam logic [2:0] S_ENQ    = 3'd3;
	localparam logic [2:0] S_RD     = 3'd4;
	localparam logic [2:0] S_RD_ENT = 3'd5;
	localparam logic [2:0] S_POP    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] func_q, st_q, st_d;
	logic       pk_q, pk_d, rot_q, rot_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= 2'd0;
			st_q <= rtpq_pkg::ST_OK;
			pk_q <= 1'b0;
			rot_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			pk_q <= pk_d;
			rot_q <= rot_d;
			if (start && !busy) func_q <= func;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		pk_d = pk_q;
		rot_d = rot_q;
		ctl = '0;
		status_d = st_q;
		picked_d = pk_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d = S_EVAL;
					st_d = rtpq_pkg::ST_OK;
					pk_d = 1'b0;
					rot_d = 1'b0;
				end
			end
			S_EVAL: begin
				state_d = S_IDLE;
				case (func_q)
					rtpq_pkg::FUNC_SET: begin
						if (!sts.set_ok) st_d = rtpq_pkg::ST_INVAL;
						else if (sts.pool_full) st_d = rtpq_pkg::ST_FULL;
						else state_d = S_ENQ_RD;
					end
					rtpq_pkg::FUNC_PICK: begin
						if (!sts.any_ne) st_d = rtpq_pkg::ST_EMPTY;
						else state_d = S_RD;
					end
					rtpq_pkg::FUNC_TICK: begin
						if (sts.any_ne && sts.cur_rr) begin
							if (!sts.expire) ctl.dec = 1'b1;
							else if (sts.pool_full) st_d = rtpq_pkg::ST_FULL;
							else begin
								rot_d = 1'b1;
								state_d = S_ENQ_RD;
							end
						end
					end
					default: st_d = rtpq_pkg::ST_INVAL;
				endcase
				if (state_d == S_IDLE) begin
					ctl.done = 1'b1;
					status_d = st_d;
					picked_d = 1'b0;
				end
			end
			S_ENQ_RD: begin
				ctl.enq_rd = 1'b1;
				ctl.enq_cur = rot_q;
				state_d = S_ENQ;
			end
			S_ENQ: begin
				ctl.enq = 1'b1;
				ctl.enq_cur = rot_q;
				if (rot_q) state_d = S_RD;
				else begin
					state_d = S_IDLE;
					ctl.done = 1'b1;
				end
			end
			S_RD: begin
				ctl.rd_tail = 1'b1;
				state_d = S_RD_ENT;
			end
			S_RD_ENT: begin
				ctl.rd_ent = 1'b1;
				state_d = S_POP;
			end
			S_POP: begin
				ctl.take = 1'b1;
				ctl.done = 1'b1;
				pk_d = 1'b1;
				picked_d = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

[rtl/core/rtpq_dp.sv]
// Datapath: level tables, entry pool, free map, current thread.
// Depends on rtpq_pkg.
module rtpq_dp #(
	parameter int LEVELS = rtpq_pkg::LEVELS_DEF,
	parameter int POOL_ENTRIES = rtpq_pkg::POOL_DEF,
	parameter int THREAD_ID_BITS = rtpq_pkg::TID_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rtpq_pkg::ctl_t            ctl,
	output rtpq_pkg::sts_t            sts,
	input  logic [THREAD_ID_BITS-1:0] thread_id,
	input  logic [7:0]                priority_req,
	input  logic [1:0]                sched_policy,
	input  logic [31:0]               task_period,
	input  logic [31:0]               rel_deadline,
	input  logic [19:0]               quantum_us,
	input  logic [19:0]               tick_us,
	output logic [THREAD_ID_BITS-1:0] cur_thread,
	output logic [6:0]                cur_priority,
	output logic                      any_ne
);
	localparam int LB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int EB = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

	logic [EB-1:0] head_mem [LEVELS];
	logic [EB-1:0] tail_mem [LEVELS];
	logic [EB-1:0] link_mem [POOL_ENTRIES];
	logic [THREAD_ID_BITS-1:0] thr_mem [POOL_ENTRIES];
	logic cls_mem [POOL_ENTRIES];

	logic [LEVELS-1:0] ne_q;
	logic [POOL_ENTRIES-1:0] free_q;
	logic cur_valid_q, cur_class_q;
	logic [THREAD_ID_BITS-1:0] cur_thread_q, tid_q;
	logic [6:0] cur_prio_q;
	logic [19:0] cur_rem_q;
	logic [7:0] prio_q;
	logic cls_q, setok_q;

	// registered search results
	logic [LB-1:0] top_q;
	logic [EB-1:0] free_idx_q;
	logic full_q;
	logic [EB-1:0] tl_q, hd_q, lnk_q, etl_q;
	logic [THREAD_ID_BITS-1:0] pthr_q;
	logic pcls_q;

	logic [LB-1:0] top_c;
	logic [EB-1:0] fidx_c;

	always_comb begin
		top_c = '0;
		for (int i = 0; i < LEVELS; i++) if (ne_q[i]) top_c = LB'(i);
		fidx_c = '0;
		for (int i = POOL_ENTRIES - 1; i >= 0; i--) if (free_q[i]) fidx_c = EB'(i);
	end

	logic [LB-1:0] eprio;
	logic [THREAD_ID_BITS-1:0] etid;
	logic ecls;
	assign eprio = ctl.enq_cur ? LB'(cur_prio_q) : LB'(prio_q);
	assign etid = ctl.enq_cur ? cur_thread_q : tid_q;
	assign ecls = ctl.enq_cur ? cur_class_q : cls_q;

	assign any_ne = |ne_q;
	assign cur_thread = cur_thread_q;
	assign cur_priority = cur_prio_q;
	assign sts.set_ok = setok_q;
	assign sts.pool_full = full_q;
	assign sts.any_ne = any_ne;
	assign sts.cur_rr = cur_valid_q && cur_class_q;
	assign sts.expire = (cur_rem_q <= tick_us);

	always_ff @(posedge clk) begin
		top_q <= top_c;
		free_idx_q <= fidx_c;
		full_q <= ~|free_q;
		if (ctl.latch) begin
			tid_q <= thread_id;
			prio_q <= priority_req;
			cls_q <= sched_policy[0];
			setok_q <= (priority_req >= 8'd1) && (32'(priority_req) < 32'(LEVELS))
				&& (priority_req <= 8'd99) && (sched_policy <= 2'd1)
				&& (rel_deadline <= task_period);
		end
		if (ctl.enq_rd) etl_q <= tail_mem[eprio];
		if (ctl.enq) begin
			thr_mem[free_idx_q] <= etid;
			cls_mem[free_idx_q] <= ecls;
			if (ne_q[eprio]) link_mem[etl_q] <= free_idx_q;
			else head_mem[eprio] <= free_idx_q;
			tail_mem[eprio] <= free_idx_q;
		end
		// live search: a rotation may have just made a higher level non-empty
		if (ctl.rd_tail) begin
			tl_q <= tail_mem[top_c];
			hd_q <= head_mem[top_c];
		end
		if (ctl.rd_ent) begin
			lnk_q <= link_mem[hd_q];
			pthr_q <= thr_mem[hd_q];
			pcls_q <= cls_mem[hd_q];
		end
		if (ctl.take && hd_q != tl_q) head_mem[top_q] <= lnk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
			free_q <= '1;
			cur_valid_q <= 1'b0;
			cur_class_q <= 1'b0;
			cur_thread_q <= '0;
			cur_prio_q <= '0;
			cur_rem_q <= '0;
		end else begin
			if (ctl.enq) begin
				free_q[free_idx_q] <= 1'b0;
				ne_q[eprio] <= 1'b1;
			end
			if (ctl.dec) cur_rem_q <= cur_rem_q - tick_us;
			if (ctl.take) begin
				if (hd_q == tl_q) ne_q[top_q] <= 1'b0;
				free_q[hd_q] <= 1'b1;
				cur_valid_q <= 1'b1;
				cur_thread_q <= pthr_q;
				cur_prio_q <= 7'(top_q);
				cur_class_q <= pcls_q;
				cur_rem_q <= quantum_us;
			end
		end
	end
endmodule

[rtl/core/rt_priority_run_queue_unit.sv]
// Top level of the real-time priority run queue.
// Depends on rtpq_pkg, rtpq_ctrl, rtpq_dp.
//
// Usage: raise start with func and the set fields while busy is low; the beat
// is taken at that edge and busy rises. One result beat follows, shown on
// the result ports for one cycle with done high; the receiver cannot stall.
// Set-invalid, set or rotation into a full pool, pick-empty, tick without
// rotation and invalid func end in the check state; a set adds the enqueue,
// a pick the dequeue, and a rotating tick the enqueue then the dequeue. busy
// drops as done rises, so the next beat can be taken at the edge that ends
// the result cycle, but not while a beat is in flight. Each step is one
// controller state: check, tail read and write for the enqueue, head/tail
// read, entry read and pop for the dequeue; all table reads are registered.
// Registers quantum_us (0x0) and tick_us (0x4) must be written over the APB
// port only while idle; the block does not enforce it. pready is always high.
// Reset empties all levels, frees all entries, clears the current thread
// and restores both registers to their defaults.
module rt_priority_run_queue_unit #(
	parameter int LEVELS = rtpq_pkg::LEVELS_DEF,
	parameter int POOL_ENTRIES = rtpq_pkg::POOL_DEF,
	parameter int THREAD_ID_BITS = rtpq_pkg::TID_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [THREAD_ID_BITS-1:0] thread_id,
	input  logic [7:0]                priority_req,
	input  logic [1:0]                sched_policy,
	input  logic [31:0]               task_period,
	input  logic [31:0]               rel_deadline,
	output logic                      done,
	output logic [1:0]                status,
	output logic                      picked_valid,
	output logic [15:0]               picked_thread,
	output logic [6:0]                picked_priority,
	output logic                      runnable,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	rtpq_pkg::ctl_t ctl;
	rtpq_pkg::sts_t sts;
	logic [19:0] quantum_q, tick_q;
	logic [1:0] st_d;
	logic pk_d, any_ne, done_q, pk_q;
	logic [1:0] st_q;
	logic [THREAD_ID_BITS-1:0] cthr;
	logic [6:0] cprio;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rtpq_pkg::QUANTUM_RST;
			tick_q <= rtpq_pkg::TICK_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == rtpq_pkg::ADDR_QUANTUM) quantum_q <= pwdata[19:0];
			else tick_q <= pwdata[19:0];
		end
	end
	assign prdata = {12'd0, (paddr[2] == rtpq_pkg::ADDR_TICK) ? tick_q : quantum_q};

	rtpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func), .busy(busy),
		.sts(sts), .ctl(ctl), .status_d(st_d), .picked_d(pk_d)
	);

	rtpq_dp #(.LEVELS(LEVELS), .POOL_ENTRIES(POOL_ENTRIES),
		.THREAD_ID_BITS(THREAD_ID_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.thread_id(thread_id), .priority_req(priority_req),
		.sched_policy(sched_policy), .task_period(task_period),
		.rel_deadline(rel_deadline), .quantum_us(quantum_q), .tick_us(tick_q),
		.cur_thread(cthr), .cur_priority(cprio), .any_ne(any_ne)
	);

	// result beat shows state after the final update edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			st_q <= rtpq_pkg::ST_OK;
			pk_q <= 1'b0;
		end else begin
			done_q <= ctl.done;
			if (ctl.done) begin
				st_q <= st_d;
				pk_q <= pk_d;
			end
		end
	end

	assign done = done_q;
	assign status = st_q;
	assign picked_valid = pk_q;
	assign picked_thread = pk_q ? 16'(cthr) : 16'd0;
	assign picked_priority = pk_q ? cprio : 7'd0;
	assign runnable = any_ne;
endmodule

[rtl/core/rtpq_checker.sv]
// Port-level checks for the run queue top level, with its bind.
// Depends on rt_priority_run_queue_unit.
module rtpq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic       picked_valid,
	input logic [6:0] picked_priority
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_pick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && picked_valid) |-> (status == 2'd0 && picked_priority != 7'd0))
		else $error("pick with bad status");
	a_idle_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !$past(busy)) |-> !done) else $error("spurious done");
endmodule

bind rt_priority_run_queue_unit rtpq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .picked_valid(picked_valid),
	.picked_priority(picked_priority)
);

[tb/rt_priority_run_queue_unit_tb.sv]
// Self-checking testbench for rt_priority_run_queue_unit: directed table then random
// set/pick/tick traffic, each result beat checked against a behavioral run-queue model.
// Depends on rtpq_pkg and the unit RTL only.
module rt_priority_run_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NLVL = 100;
	localparam int NENT = 64;
	localparam logic [1:0] FUNC_BAD = 2'd3;
	localparam logic [1:0] F_SET = rtpq_pkg::FUNC_SET;
	localparam logic [1:0] F_PICK = rtpq_pkg::FUNC_PICK;
	localparam logic [1:0] F_TICK = rtpq_pkg::FUNC_TICK;
	localparam logic [1:0] S_OK = rtpq_pkg::ST_OK;
	localparam logic [1:0] S_INV = rtpq_pkg::ST_INVAL;
	localparam logic [1:0] S_FULL = rtpq_pkg::ST_FULL;
	localparam logic [1:0] S_EMPTY = rtpq_pkg::ST_EMPTY;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] tid;
		logic [7:0]  prio;
		logic [1:0]  cls;
		logic [31:0] period;
		logic [31:0] deadline;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        pv;
		logic [15:0] pt;
		logic [6:0]  pp;
		logic        run;
	} res_t;

	logic clk, arst_n, start, busy, done;
	logic [1:0] func, sched_policy, status;
	logic [15:0] thread_id, picked_thread;
	logic [7:0] priority_req;
	logic [31:0] task_period, rel_deadline, pwdata, prdata;
	logic picked_valid, runnable, psel, penable, pwrite, pready;
	logic [6:0] picked_priority;
	logic [2:0] paddr;

	rt_priority_run_queue_unit dut (.*);

	// run-queue model state
	logic [19:0] m_quantum, m_tick;
	bit          lvl_ne [NLVL];
	int          lvl_head [NLVL], lvl_tail [NLVL];
	int          ent_link [NENT];
	logic [15:0] ent_tid [NENT];
	bit          ent_rr [NENT], ent_free [NENT];
	bit          cur_v, cur_rr;
	logic [15:0] cur_tid;
	logic [6:0]  cur_prio;
	logic [19:0] cur_rem;

	res_t sched_expect_q[$];
	int   n_err;
	int   idle_pct;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		n_err++;
	endtask

	function automatic void rq_reset();
		m_quantum = rtpq_pkg::QUANTUM_RST;
		m_tick = rtpq_pkg::TICK_RST;
		for (int i = 0; i < NLVL; i++) lvl_ne[i] = 0;
		for (int i = 0; i < NENT; i++) ent_free[i] = 1;
		cur_v = 0; cur_rr = 0; cur_tid = '0; cur_prio = '0; cur_rem = '0;
	endfunction

	function automatic bit rq_any();
		foreach (lvl_ne[i]) if (lvl_ne[i]) return 1;
		return 0;
	endfunction

	function automatic bit rq_push(input int p, input logic [15:0] t, input bit rr);
		int e;
		e = -1;
		for (int i = NENT - 1; i >= 0; i--) if (ent_free[i]) e = i;
		if (e < 0) return 0;
		ent_free[e] = 0; ent_tid[e] = t; ent_rr[e] = rr; ent_link[e] = 0;
		if (lvl_ne[p]) begin
			ent_link[lvl_tail[p]] = e;
			lvl_tail[p] = e;
		end else begin
			lvl_head[p] = e; lvl_tail[p] = e; lvl_ne[p] = 1;
		end
		return 1;
	endfunction

	function automatic bit rq_take_top();
		int e;
		for (int p = NLVL - 1; p >= 0; p--) begin
			if (!lvl_ne[p]) continue;
			e = lvl_head[p];
			if (e == lvl_tail[p]) lvl_ne[p] = 0;
			else lvl_head[p] = ent_link[e];
			ent_free[e] = 1;
			cur_v = 1; cur_tid = ent_tid[e]; cur_prio = p[6:0];
			cur_rr = ent_rr[e]; cur_rem = m_quantum;
			return 1;
		end
		return 0;
	endfunction

	function automatic res_t rq_step(input cmd_t c);
		res_t r;
		r = '0;
		r.status = S_OK;
		case (c.func)
			F_SET: begin
				if (c.prio < 1 || c.prio > NLVL - 1 || c.cls > 1 || c.deadline > c.period)
					r.status = S_INV;
				else if (!rq_push(int'(c.prio), c.tid, c.cls[0]))
					r.status = S_FULL;
			end
			F_PICK: if (rq_take_top()) r.pv = 1; else r.status = S_EMPTY;
			F_TICK: begin
				if (rq_any() && cur_v && cur_rr) begin
					if (cur_rem <= m_tick) begin
						if (!rq_push(int'(cur_prio), cur_tid, cur_rr)) r.status = S_FULL;
						else r.pv = rq_take_top();
					end else cur_rem = cur_rem - m_tick;
				end
			end
			default: r.status = S_INV;
		endcase
		if (r.pv) begin
			r.pt = cur_tid;
			r.pp = cur_prio;
		end
		r.run = rq_any();
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && done) begin
			got = '{status, picked_valid, picked_thread, picked_priority, runnable};
			if (sched_expect_q.size() == 0) report_mismatch("result with nothing expected");
			else begin
				want = sched_expect_q.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d exp %0d", got.status, want.status));
				if (got.pv !== want.pv)
					report_mismatch($sformatf("picked_valid %0d exp %0d", got.pv, want.pv));
				if (got.pt !== want.pt)
					report_mismatch($sformatf("picked_thread %0h exp %0h", got.pt, want.pt));
				if (got.pp !== want.pp)
					report_mismatch($sformatf("picked_priority %0d exp %0d", got.pp, want.pp));
				if (got.run !== want.run)
					report_mismatch($sformatf("runnable %0d exp %0d", got.run, want.run));
			end
		end
	end

	task automatic reg_write(input logic addr, input logic [19:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {addr, 2'b00}; pwdata <= {12'h0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == rtpq_pkg::ADDR_QUANTUM) m_quantum = val; else m_tick = val;
	endtask

	// beat accepted at the edge where start && !busy; start stays up into the next beat
	task automatic issue(input cmd_t c, input bit has_exp, input res_t exp_r);
		res_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1; func <= c.func; thread_id <= c.tid; priority_req <= c.prio;
		sched_policy <= c.cls; task_period <= c.period; rel_deadline <= c.deadline;
		do @(posedge clk); while (busy);
		r = rq_step(c);
		if (has_exp && r !== exp_r) report_mismatch("model disagrees with table row");
		sched_expect_q.push_back(r);
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 0;
		while (sched_expect_q.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int k;
		c.tid = 16'($urandom);
		c.period = $urandom;
		c.deadline = $urandom;
		c.prio = 8'($urandom_range(1, 99));
		c.cls = 2'($urandom_range(1));
		k = int'($urandom_range(99));
		if (k < 40) c.func = F_SET;
		else if (k < 60) c.func = F_PICK;
		else if (k < 95) c.func = F_TICK;
		else c.func = FUNC_BAD;
		if (c.func == F_SET) begin
			if ($urandom_range(9) == 0) begin
				c.prio = 8'($urandom); c.cls = 2'($urandom);
			end else if (c.deadline > c.period && $urandom_range(7) != 0) begin
				c.deadline = c.period - $urandom_range(100);
				if (c.deadline > c.period) c.deadline = c.period;
			end
		end
		return c;
	endfunction

	typedef struct packed {
		cmd_t c;
		bit   has;
		res_t r;
	} row_t;

	initial begin
		row_t dir [$];
		cmd_t c;
		arst_n = 0; start = 0; func = F_SET; thread_id = 0; priority_req = 0;
		sched_policy = 0; task_period = 0; rel_deadline = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		n_err = 0; idle_pct = 0;
		rq_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// func, tid, prio, cls, period, deadline | expected where obvious
		dir = '{
			'{'{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1, '{S_EMPTY, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_TICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1, '{S_OK, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{FUNC_BAD, 16'hFFFF, 8'hFF, 2'd3, '1, '1}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'h1, 8'd0, 2'd0, 32'd5, 32'd5}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'h1, 8'd100, 2'd0, 32'd5, 32'd5}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'h1, 8'd255, 2'd0, 32'd5, 32'd5}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'h1, 8'd5, 2'd2, 32'd5, 32'd5}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'h1, 8'd5, 2'd3, 32'd5, 32'd5}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'h1, 8'd5, 2'd0, 32'd5, 32'd6}, 1, '{S_INV, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_SET, 16'hFFFF, 8'd99, 2'd1, '1, '1}, 1, '{S_OK, 1'b0, 16'h0, 7'd0, 1'b1}},
			'{'{F_SET, 16'h0, 8'd1, 2'd0, 32'd0, 32'd0}, 1, '{S_OK, 1'b0, 16'h0, 7'd0, 1'b1}},
			'{'{F_SET, 16'hAAAA, 8'd99, 2'd1, 32'd7, 32'd3}, 0, '0},
			'{'{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1,
				'{S_OK, 1'b1, 16'hFFFF, 7'd99, 1'b1}},
			'{'{F_TICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 0, '0},
			'{'{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 0, '0},
			'{'{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1, '{S_OK, 1'b1, 16'h0, 7'd1, 1'b0}},
			'{'{F_TICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1, '{S_OK, 1'b0, 16'h0, 7'd0, 1'b0}},
			'{'{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1, '{S_EMPTY, 1'b0, 16'h0, 7'd0, 1'b0}}
		};
		foreach (dir[i]) issue(dir[i].c, dir[i].has, dir[i].r);
		drain();

		// fill the pool: 64 sets fit, then pool full; rr current then rotates into a full pool
		for (int i = 0; i < 66; i++) begin
			c = '{F_SET, 16'(i), 8'(1 + i % 3), 2'd1, 32'd10, 32'd1};
			issue(c, 0, '0);
		end
		issue('{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 0, '0);
		issue('{F_SET, 16'h5A5A, 8'd50, 2'd0, 32'd1, 32'd0}, 0, '0);
		drain();
		reg_write(rtpq_pkg::ADDR_TICK, 20'hFFFFF);
		issue('{F_TICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 1,
			'{S_FULL, 1'b0, 16'h0, 7'd0, 1'b1});
		while (rq_any()) issue('{F_PICK, 16'h0, 8'd0, 2'd0, 32'd0, 32'd0}, 0, '0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					reg_write(rtpq_pkg::ADDR_QUANTUM, 20'd1);
					reg_write(rtpq_pkg::ADDR_TICK, 20'd1);
				end
				1: begin
					reg_write(rtpq_pkg::ADDR_QUANTUM, 20'd3000);
					reg_write(rtpq_pkg::ADDR_TICK, 20'd1000);
				end
				2: begin
					reg_write(rtpq_pkg::ADDR_QUANTUM, 20'hFFFFF);
					reg_write(rtpq_pkg::ADDR_TICK, 20'd1);
				end
				3: begin
					reg_write(rtpq_pkg::ADDR_QUANTUM, 20'($urandom));
					reg_write(rtpq_pkg::ADDR_TICK, 20'($urandom));
				end
				default: begin
					reg_write(rtpq_pkg::ADDR_QUANTUM, rtpq_pkg::QUANTUM_RST);
					reg_write(rtpq_pkg::ADDR_TICK, rtpq_pkg::TICK_RST);
				end
			endcase
			idle_pct = (ph == 1) ? 70 : (ph == 3) ? 13 : 0;
			for (int i = 0; i < 120; i++) issue(rand_cmd(), 0, '0);
			drain();
		end

		if (n_err == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
